### rtl/core/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

### rtl/core/hsv2rgb_pkg.sv
package hsv2rgb_pkg;

   localparam int unsigned HUE_W             = 16;
   localparam int unsigned PCT_W             = 7;
   localparam int unsigned BYTE_W            = 8;
   localparam int unsigned PRD_W             = 14;   // holds a product of two percents
   localparam int unsigned HUE_FRAC_BITS_DEF = 4;
   localparam int unsigned PCT_FULL          = 100;
   localparam int unsigned PCT_SQ            = 10000;
   localparam int unsigned BYTE_MAX          = 255;
   localparam int unsigned RECIP_SHIFT       = 32;   // fixed-point scale of reciprocals

endpackage

### rtl/core/hsv2rgb_if.sv
interface hsv2rgb_req_if;
   import hsv2rgb_pkg::*;

   logic             valid;
   logic             ready;
   logic [HUE_W-1:0] hue;
   logic [PCT_W-1:0] saturation;
   logic [PCT_W-1:0] brightness;

   modport source (output valid, output hue, output saturation, output brightness,
                   input ready);
   modport sink   (input valid, input hue, input saturation, input brightness,
                   output ready);
endinterface

interface hsv2rgb_rsp_if;
   import hsv2rgb_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] red;
   logic [BYTE_W-1:0] green;
   logic [BYTE_W-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

### rtl/core/hsv_to_rgb_converter.sv
// HSV to 8-bit RGB converter, seven register stages.
// A word accepted on req_chan passes through stages 1 to 7 in order and shows on
// rsp_chan from the stage 7 register.
// Throughput: one word per clock unless stalled; a full stage waits for its
// successor to move; output stalls fill bubbles before req_chan.ready drops.
// Reset (synchronous, active high) empties every stage; payload is not cleared.
`include "assert_macros.svh"

module hsv_to_rgb_converter #(
   parameter int unsigned HUE_FRAC_BITS = hsv2rgb_pkg::HUE_FRAC_BITS_DEF
) (
   input logic            clock,
   input logic            reset,
   hsv2rgb_req_if.sink    req_chan,
   hsv2rgb_rsp_if.source  rsp_chan
);
   import hsv2rgb_pkg::*;

   localparam int unsigned STAGES = 7;
   localparam int unsigned CHANS  = 3;

   // Angle spans in hue units.
   localparam longint unsigned UNIT = 64'd1 << HUE_FRAC_BITS;
   localparam longint unsigned SPAN = 60 * UNIT;         // one 60-degree sector
   localparam longint unsigned TURN = 6 * SPAN;          // full turn
   localparam longint unsigned DEN  = PCT_SQ * SPAN;     // common denominator

   // Hue reduction: quotient estimate by reciprocal, then one correction.
   localparam longint unsigned RECIP_TURN = (64'd1 << RECIP_SHIFT) / TURN;
   localparam int unsigned HW   = $clog2(TURN);
   localparam int unsigned RW   = ((HW > HUE_W) ? HW : HUE_W) + 1;
   localparam int unsigned RTW  = $clog2(RECIP_TURN + 1);
   localparam int unsigned QW   = $clog2(((64'd1 << HUE_W) - 1) / TURN + 2);
   localparam int unsigned HPW  = (HUE_W + RTW > RECIP_SHIFT + QW) ?
                                  HUE_W + RTW : RECIP_SHIFT + QW;

   // Sector position and channel numerators.
   localparam int unsigned SW   = $clog2(SPAN + 1);
   localparam int unsigned NW   = $clog2(DEN + 1);

   // Final scale by 255/DEN: estimate by reciprocal, then one correction.
   localparam longint unsigned RECIP_DEN = (longint'(BYTE_MAX) << RECIP_SHIFT) / DEN;
   localparam int unsigned RDW  = $clog2(RECIP_DEN + 1);
   localparam int unsigned QPW  = (NW + RDW > RECIP_SHIFT + BYTE_W) ?
                                  NW + RDW : RECIP_SHIFT + BYTE_W;
   localparam int unsigned LW   = NW + BYTE_W + 1;

   // Sectors, named by the hues they run between.
   typedef enum logic [2:0] {
      SEC_RY, SEC_YG, SEC_GC, SEC_CB, SEC_BM, SEC_MR
   } sector_type;

   function automatic logic [PCT_W-1:0] clamp_pct(input logic [PCT_W-1:0] x);
      return (x > PCT_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : x;
   endfunction

   // ------------------------------------------------------------------
   // Flow control: a stage loads when it is empty or its successor moves.
   // ------------------------------------------------------------------
   logic [STAGES:1]   vld_ff;
   logic [STAGES+1:1] move;

   always_comb begin
      move[STAGES+1] = rsp_chan.ready;
      for (int k = STAGES; k >= 1; k--) begin
         move[k] = !vld_ff[k] || move[k+1];
      end
   end

   assign req_chan.ready = move[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (move[1]) begin
            vld_ff[1] <= req_chan.valid;
         end
         for (int k = 2; k <= STAGES; k++) begin
            if (move[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: clamp percents, estimate the number of whole turns.
   // ------------------------------------------------------------------
   logic [HPW-1:0]   hue_prod;
   logic [QW-1:0]    turns1_ff;
   logic [HUE_W-1:0] hue1_ff;
   logic [PCT_W-1:0] sat1_ff, val1_ff;

   assign hue_prod = HPW'(req_chan.hue) * HPW'(RECIP_TURN);

   always_ff @(posedge clock) begin
      if (move[1]) begin
         turns1_ff <= hue_prod[RECIP_SHIFT +: QW];
         hue1_ff   <= req_chan.hue;
         sat1_ff   <= clamp_pct(req_chan.saturation);
         val1_ff   <= clamp_pct(req_chan.brightness);
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: finish hue mod turn; chroma and offset percent products.
   // ------------------------------------------------------------------
   logic [RW-1:0]    hue_diff;
   logic [HW-1:0]    ang2_in, ang2_ff;
   logic [PRD_W-1:0] chr2_ff, off2_ff;

   always_comb begin
      hue_diff = RW'(hue1_ff) - RW'(turns1_ff) * RW'(TURN);
      // the estimate is low by at most one turn
      if (hue_diff >= RW'(TURN)) begin
         ang2_in = HW'(hue_diff - RW'(TURN));
      end else begin
         ang2_in = HW'(hue_diff);
      end
   end

   always_ff @(posedge clock) begin
      if (move[2]) begin
         ang2_ff <= ang2_in;
         chr2_ff <= PRD_W'(sat1_ff) * PRD_W'(val1_ff);
         off2_ff <= PRD_W'(val1_ff) * PRD_W'(PCT_W'(PCT_FULL) - sat1_ff);
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: sector and distance to the nearer primary.
   // ------------------------------------------------------------------
   sector_type       sec3_in, sec3_ff;
   logic [HW-1:0]    base3;
   logic [HW-1:0]    frac3;
   logic [SW-1:0]    tri3_in, tri3_ff;
   logic [PRD_W-1:0] chr3_ff, off3_ff;

   always_comb begin
      if (ang2_ff >= HW'(5 * SPAN)) begin
         sec3_in = SEC_MR;
         base3   = HW'(5 * SPAN);
      end else if (ang2_ff >= HW'(4 * SPAN)) begin
         sec3_in = SEC_BM;
         base3   = HW'(4 * SPAN);
      end else if (ang2_ff >= HW'(3 * SPAN)) begin
         sec3_in = SEC_CB;
         base3   = HW'(3 * SPAN);
      end else if (ang2_ff >= HW'(2 * SPAN)) begin
         sec3_in = SEC_GC;
         base3   = HW'(2 * SPAN);
      end else if (ang2_ff >= HW'(SPAN)) begin
         sec3_in = SEC_YG;
         base3   = HW'(SPAN);
      end else begin
         sec3_in = SEC_RY;
         base3   = '0;
      end
      frac3 = ang2_ff - base3;
      // falling edge of the triangle in odd sectors
      if (sec3_in inside {SEC_YG, SEC_CB, SEC_MR}) begin
         tri3_in = SW'(SPAN) - SW'(frac3);
      end else begin
         tri3_in = SW'(frac3);
      end
   end

   always_ff @(posedge clock) begin
      if (move[3]) begin
         sec3_ff <= sec3_in;
         tri3_ff <= tri3_in;
         chr3_ff <= chr2_ff;
         off3_ff <= off2_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: numerators over DEN for C, X and m.
   // ------------------------------------------------------------------
   sector_type    sec4_ff;
   logic [NW-1:0] cn4_ff, xn4_ff, mn4_ff;

   always_ff @(posedge clock) begin
      if (move[4]) begin
         sec4_ff <= sec3_ff;
         cn4_ff  <= NW'(chr3_ff) * NW'(SPAN);
         xn4_ff  <= NW'(chr3_ff) * NW'(tri3_ff);
         mn4_ff  <= NW'(off3_ff) * NW'(SPAN);
      end
   end

   // ------------------------------------------------------------------
   // Stage 5: arrange by sector and add the offset. Sum never exceeds DEN.
   // ------------------------------------------------------------------
   logic [NW-1:0] ch5 [CHANS];
   logic [NW-1:0] num5_ff [CHANS];

   always_comb begin
      case (sec4_ff)
         SEC_RY: begin
            ch5[0] = cn4_ff; ch5[1] = xn4_ff; ch5[2] = '0;
         end
         SEC_YG: begin
            ch5[0] = xn4_ff; ch5[1] = cn4_ff; ch5[2] = '0;
         end
         SEC_GC: begin
            ch5[0] = '0;     ch5[1] = cn4_ff; ch5[2] = xn4_ff;
         end
         SEC_CB: begin
            ch5[0] = '0;     ch5[1] = xn4_ff; ch5[2] = cn4_ff;
         end
         SEC_BM: begin
            ch5[0] = xn4_ff; ch5[1] = '0;     ch5[2] = cn4_ff;
         end
         default: begin
            ch5[0] = cn4_ff; ch5[1] = '0;     ch5[2] = xn4_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (move[5]) begin
         for (int c = 0; c < CHANS; c++) begin
            num5_ff[c] <= ch5[c] + mn4_ff;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage 6: byte estimate floor(num * 255/DEN), low by at most one.
   // ------------------------------------------------------------------
   logic [QPW-1:0]    scl6 [CHANS];
   logic [BYTE_W-1:0] est6_ff [CHANS];
   logic [NW-1:0]     num6_ff [CHANS];

   always_comb begin
      for (int c = 0; c < CHANS; c++) begin
         scl6[c] = QPW'(num5_ff[c]) * QPW'(RECIP_DEN);
      end
   end

   always_ff @(posedge clock) begin
      if (move[6]) begin
         for (int c = 0; c < CHANS; c++) begin
            est6_ff[c] <= scl6[c][RECIP_SHIFT +: BYTE_W];
            num6_ff[c] <= num5_ff[c];
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage 7: bump the estimate when 255*num still reaches (est+1)*DEN.
   // ------------------------------------------------------------------
   logic [LW-1:0]     lhs7 [CHANS];
   logic [LW-1:0]     rhs7 [CHANS];
   logic [BYTE_W-1:0] rgb7_in [CHANS];
   logic [BYTE_W-1:0] rgb7_ff [CHANS];

   always_comb begin
      for (int c = 0; c < CHANS; c++) begin
         lhs7[c] = LW'(num6_ff[c]) * LW'(BYTE_MAX);
         rhs7[c] = LW'((BYTE_W + 1)'(est6_ff[c]) + (BYTE_W + 1)'(1)) * LW'(DEN);
         if (lhs7[c] >= rhs7[c] && est6_ff[c] != BYTE_W'(BYTE_MAX)) begin
            rgb7_in[c] = est6_ff[c] + BYTE_W'(1);
         end else begin
            rgb7_in[c] = est6_ff[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (move[7]) begin
         for (int c = 0; c < CHANS; c++) begin
            rgb7_ff[c] <= rgb7_in[c];
         end
      end
   end

   assign rsp_chan.valid = vld_ff[STAGES];
   assign rsp_chan.red   = rgb7_ff[0];
   assign rsp_chan.green = rgb7_ff[1];
   assign rsp_chan.blue  = rgb7_ff[2];

   // ------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------
   // a full pipe with a stalled output must refuse new words
   `ASSERT_IMP(a_full_stall, clock, reset, (&vld_ff) && !rsp_chan.ready, !req_chan.ready)
   // hue reduction lands inside one turn
   `ASSERT_IMP(a_ang_range, clock, reset, vld_ff[2], ang2_ff < HW'(TURN))
   // triangle position never exceeds a sector
   `ASSERT_IMP(a_tri_range, clock, reset, vld_ff[3], tri3_ff <= SW'(SPAN))
   // channel plus offset never exceeds full scale
   `ASSERT_IMP(a_num_range, clock, reset, vld_ff[5],
               num5_ff[0] <= NW'(DEN) && num5_ff[1] <= NW'(DEN) && num5_ff[2] <= NW'(DEN))

endmodule

### test/hsv_to_rgb_converter_tb.sv
`timescale 1ns / 1ps

module hsv_to_rgb_converter_tb;
   import hsv2rgb_pkg::*;

   // One process drives color words, one drives the result ready, and one
   // monitor at the rising edge records the expected RGB of every accepted
   // color word and checks every accepted result word in order.

   // ---------------------------------------------------------------------
   // Run shape
   // ---------------------------------------------------------------------
   localparam int unsigned HUE_FRAC     = HUE_FRAC_BITS_DEF;
   localparam int unsigned HUE_UNIT     = 1 << HUE_FRAC;
   localparam int unsigned SECTOR_SPAN  = 60 * HUE_UNIT;   // one 60 degree sector
   localparam int unsigned TURN_SPAN    = 360 * HUE_UNIT;  // one full turn
   localparam int unsigned PCT_MAX_CODE = (1 << PCT_W) - 1;

   localparam int unsigned RESET_CYCLES     = 11;
   localparam int unsigned RANDOM_WORDS     = 1427;
   localparam int unsigned CALM_WORDS       = 200;   // tail of the run with no idling
   localparam int unsigned LONG_HOLD_AFTER  = 300;   // accepted words before the long hold
   localparam int unsigned LONG_HOLD_CYCLES = 60;    // well past the seven-stage pipe
   localparam int unsigned DRAIN_CYCLES     = 20;    // pipe is seven stages deep
   localparam int unsigned CYCLE_LIMIT      = 200000;

   // 60 degree hue sectors, in channel-arrangement order
   typedef enum int unsigned {
      SEC_RED_YELLOW,
      SEC_YELLOW_GREEN,
      SEC_GREEN_CYAN,
      SEC_CYAN_BLUE,
      SEC_BLUE_MAGENTA,
      SEC_MAGENTA_RED
   } hue_sector_type;

   typedef struct packed {
      logic [HUE_W-1:0] hue;
      logic [PCT_W-1:0] saturation;
      logic [PCT_W-1:0] brightness;
   } hsv_word_type;

   typedef struct packed {
      logic [BYTE_W-1:0] red;
      logic [BYTE_W-1:0] green;
      logic [BYTE_W-1:0] blue;
   } rgb_word_type;

   // Directed row: color, whether the RGB is given here, and that RGB.
   typedef struct packed {
      hsv_word_type color;
      logic         given;
      rgb_word_type rgb;
   } color_row_type;

   localparam int unsigned DIRECTED_WORDS = 23;

   // Rows with given=1 can be read straight off the conversion: black,
   // primaries and secondaries at full scale, wrap, clamp, grays.
   // The rest go through the predictor.
   localparam color_row_type COLOR_ROWS [DIRECTED_WORDS] = '{
      '{'{16'd0,     7'd0,   7'd0  }, 1'b1, '{8'd0,   8'd0,   8'd0  }}, // black
      '{'{16'd0,     7'd100, 7'd100}, 1'b1, '{8'd255, 8'd0,   8'd0  }}, // red
      '{'{16'd960,   7'd100, 7'd100}, 1'b1, '{8'd255, 8'd255, 8'd0  }}, // yellow
      '{'{16'd1920,  7'd100, 7'd100}, 1'b1, '{8'd0,   8'd255, 8'd0  }}, // green
      '{'{16'd2880,  7'd100, 7'd100}, 1'b1, '{8'd0,   8'd255, 8'd255}}, // cyan
      '{'{16'd3840,  7'd100, 7'd100}, 1'b1, '{8'd0,   8'd0,   8'd255}}, // blue
      '{'{16'd4800,  7'd100, 7'd100}, 1'b1, '{8'd255, 8'd0,   8'd255}}, // magenta
      '{'{16'd5760,  7'd100, 7'd100}, 1'b1, '{8'd255, 8'd0,   8'd0  }}, // one turn wraps
      '{'{16'd0,     7'd127, 7'd127}, 1'b1, '{8'd255, 8'd0,   8'd0  }}, // both clamped
      '{'{16'd3000,  7'd0,   7'd100}, 1'b1, '{8'd255, 8'd255, 8'd255}}, // white
      '{'{16'd1234,  7'd0,   7'd50 }, 1'b1, '{8'd127, 8'd127, 8'd127}}, // mid gray
      '{'{16'd65535, 7'd127, 7'd0  }, 1'b1, '{8'd0,   8'd0,   8'd0  }}, // zero value
      '{'{16'd4321,  7'd0,   7'd127}, 1'b1, '{8'd255, 8'd255, 8'd255}}, // gray, clamped v
      '{'{16'd65535, 7'd100, 7'd100}, 1'b0, '0},                        // hue max
      '{'{16'd5759,  7'd100, 7'd100}, 1'b0, '0},                        // just below a turn
      '{'{16'd959,   7'd100, 7'd100}, 1'b0, '0},                        // sector edges
      '{'{16'd961,   7'd55,  7'd77 }, 1'b0, '0},
      '{'{16'd1,     7'd1,   7'd1  }, 1'b0, '0},
      '{'{16'd2000,  7'd101, 7'd100}, 1'b0, '0},                        // s just over 100
      '{'{16'h8000,  7'd100, 7'd100}, 1'b0, '0},
      '{'{16'h5555,  7'h55,  7'h2A }, 1'b0, '0},                        // bit patterns
      '{'{16'hAAAA,  7'h2A,  7'h55 }, 1'b0, '0},
      '{'{16'd30000, 7'd64,  7'd64 }, 1'b0, '0}
   };

   // ---------------------------------------------------------------------
   // Clock, reset, channels, block
   // ---------------------------------------------------------------------
   logic clock;
   logic reset;

   hsv2rgb_req_if req_if ();
   hsv2rgb_rsp_if rsp_if ();

   hsv_to_rgb_converter #(
      .HUE_FRAC_BITS(HUE_FRAC)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Shared bench state
   // ---------------------------------------------------------------------
   rgb_word_type rgb_due [$];        // expected RGB, oldest first
   rgb_word_type offer_rgb;          // expectation for the color word on offer
   int unsigned  send_gap_pct;       // chance of a gap before a color word
   bit           calm_tail;          // no idling on either side from here on
   bit           long_hold_done;
   int unsigned  words_accepted;
   int unsigned  results_checked;
   int unsigned  input_stall_cycles; // cycles with a color word offered but refused
   int unsigned  failures;
   int unsigned  cycle_count;

   // ---------------------------------------------------------------------
   // Predictor: exact ratios over D = 10000 * sector span, then floor.
   // ---------------------------------------------------------------------
   function automatic logic [BYTE_W-1:0] channel_byte(input longint unsigned num,
                                                      input longint unsigned den);
      longint unsigned q;
      q = (BYTE_MAX * num) / den;
      return (q > BYTE_MAX) ? BYTE_W'(BYTE_MAX) : BYTE_W'(q);
   endfunction

   function automatic rgb_word_type hsv_to_rgb(input hsv_word_type c);
      longint unsigned s, v, h, f, t, den, cn, xn, mn;
      longint unsigned r, g, b;
      hue_sector_type  sector;
      rgb_word_type    res;
      s = (c.saturation > PCT_FULL) ? PCT_FULL : c.saturation;
      v = (c.brightness > PCT_FULL) ? PCT_FULL : c.brightness;
      h = c.hue % TURN_SPAN;
      sector = hue_sector_type'(h / SECTOR_SPAN);
      f = h % SECTOR_SPAN;
      // falling edge of X in odd sectors
      t = (int'(sector) % 2 == 1) ? SECTOR_SPAN - f : f;
      den = PCT_SQ * SECTOR_SPAN;
      cn = s * v * SECTOR_SPAN;
      xn = s * v * t;
      mn = v * (PCT_FULL - s) * SECTOR_SPAN;
      case (sector)
         SEC_RED_YELLOW: begin
            r = cn; g = xn; b = 0;
         end
         SEC_YELLOW_GREEN: begin
            r = xn; g = cn; b = 0;
         end
         SEC_GREEN_CYAN: begin
            r = 0; g = cn; b = xn;
         end
         SEC_CYAN_BLUE: begin
            r = 0; g = xn; b = cn;
         end
         SEC_BLUE_MAGENTA: begin
            r = xn; g = 0; b = cn;
         end
         default: begin
            r = cn; g = 0; b = xn;
         end
      endcase
      res.red   = channel_byte(r + mn, den);
      res.green = channel_byte(g + mn, den);
      res.blue  = channel_byte(b + mn, den);
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Random colors
   // ---------------------------------------------------------------------
   // Percent: hits 0, 100 and the clamped range often.
   function automatic logic [PCT_W-1:0] random_pct();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return PCT_W'(PCT_FULL);
         2: return PCT_W'($urandom_range(PCT_FULL + 1, PCT_MAX_CODE));
         default: return PCT_W'($urandom_range(0, PCT_FULL));
      endcase
   endfunction

   function automatic hsv_word_type random_color();
      hsv_word_type c;
      int           edge_hue;
      if ($urandom_range(0, 3) == 0) begin
         // a few units either side of a sector edge, some turns up
         edge_hue = $urandom_range(0, 10) * TURN_SPAN + $urandom_range(0, 5) * SECTOR_SPAN
                    + $urandom_range(0, 4) - 2;
         c.hue = (edge_hue < 0) ? '0 : HUE_W'(edge_hue);
      end else begin
         c.hue = HUE_W'($urandom_range(0, (1 << HUE_W) - 1));
      end
      c.saturation = random_pct();
      c.brightness = random_pct();
      return c;
   endfunction

   // Idle chance for the next stretch: none, light or heavy.
   function automatic int unsigned pick_idle_pct();
      case ($urandom_range(0, 2))
         0: return 0;
         1: return 10;
         default: return 35;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Sender: called and returns at a falling edge.
   // valid stays high across back-to-back words; a gap first lowers it
   // before the word is offered.
   // ---------------------------------------------------------------------
   task automatic offer_color(input hsv_word_type c, input rgb_word_type rgb);
      if (send_gap_pct != 0 && $urandom_range(1, 100) <= send_gap_pct) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.hue        <= c.hue;
      req_if.saturation <= c.saturation;
      req_if.brightness <= c.brightness;
      offer_rgb = rgb;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Monitor: record accepted color words, then check accepted results.
   // Recording first keeps the order right even for a path that passes a word straight through.
   // ---------------------------------------------------------------------
   task automatic check_channel(input string name, input logic [BYTE_W-1:0] want,
                                input logic [BYTE_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      rgb_word_type want;
      if (!reset) begin
         if (req_if.valid && req_if.ready === 1'b1) begin
            rgb_due.push_back(offer_rgb);
            words_accepted++;
         end
         if (req_if.valid && req_if.ready !== 1'b1)
            input_stall_cycles++;
         if (rsp_if.valid === 1'b1 && rsp_if.ready) begin
            if (rgb_due.size() == 0) begin
               $error("unexpected result word: red %0d green %0d blue %0d",
                      rsp_if.red, rsp_if.green, rsp_if.blue);
               failures++;
            end else begin
               want = rgb_due.pop_front();
               check_channel("red",   want.red,   rsp_if.red);
               check_channel("green", want.green, rsp_if.green);
               check_channel("blue",  want.blue,  rsp_if.blue);
               results_checked++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: random ready bursts, one long hold to back the pipe up
   // into req_chan, then always ready in the calm tail.
   // ---------------------------------------------------------------------
   initial begin : receiver
      int unsigned hold_pct;
      int unsigned cycles;
      rsp_if.ready = 1'b0;
      hold_pct     = pick_idle_pct();
      cycles       = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         cycles++;
         if (cycles % 64 == 0)
            hold_pct = pick_idle_pct();
         if (calm_tail) begin
            rsp_if.ready <= 1'b1;
         end else if (!long_hold_done && words_accepted >= LONG_HOLD_AFTER) begin
            // sender keeps offering; the pipe fills and req_chan.ready drops
            rsp_if.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            long_hold_done = 1'b1;
            rsp_if.ready <= 1'b1;
         end else if (hold_pct != 0 && $urandom_range(1, 100) <= hold_pct) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog
   // ---------------------------------------------------------------------
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               rgb_due.size());
      $display("hsv_to_rgb_converter_tb failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------------
   initial begin : stimulus
      hsv_word_type c;
      rgb_word_type rgb;

      // every input known from time zero
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.hue         = '0;
      req_if.saturation  = '0;
      req_if.brightness  = '0;
      offer_rgb          = '0;
      calm_tail          = 1'b0;
      long_hold_done     = 1'b0;
      words_accepted     = 0;
      results_checked    = 0;
      input_stall_cycles = 0;
      failures           = 0;
      send_gap_pct       = pick_idle_pct();

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed rows: given RGB where it is obvious, else predicted
      for (int i = 0; i < DIRECTED_WORDS; i++) begin
         c   = COLOR_ROWS[i].color;
         rgb = COLOR_ROWS[i].given ? COLOR_ROWS[i].rgb : hsv_to_rgb(c);
         offer_color(c, rgb);
      end

      // random words, idle rate redrawn every 64 words, calm at the end
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i >= RANDOM_WORDS - CALM_WORDS) begin
            calm_tail    = 1'b1;
            send_gap_pct = 0;
         end else if (i % 64 == 0) begin
            send_gap_pct = pick_idle_pct();
         end
         c = random_color();
         offer_color(c, hsv_to_rgb(c));
      end
      req_if.valid <= 1'b0;

      while (rgb_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d directed and %0d random colors, %0d results checked",
               DIRECTED_WORDS, RANDOM_WORDS, results_checked);
      $display("req_chan held off for %0d cycles, incl. a %0d-cycle output stall",
               input_stall_cycles, LONG_HOLD_CYCLES);
      if (failures == 0) begin
         $display("hsv_to_rgb_converter_tb passed");
      end else begin
         $display("hsv_to_rgb_converter_tb failed");
      end
      $finish;
   end

endmodule
